// ===== src/rthc_pkg.sv =====
package rthc_pkg;

  localparam int ChanW           = 8;
  localparam int HueW            = 16;
  localparam int SpanW           = 11;
  localparam int NumW            = 12;
  localparam int HueBitsPerStage = 4;
  localparam int DivStages       = HueW / HueBitsPerStage;
  localparam int SatBitsPerStage = ChanW / DivStages;
  localparam int InDataW         = 4 * ChanW;
  localparam int OutDataW        = HueW + 3 * ChanW;

  typedef struct packed {
    logic [ChanW-1:0] alpha;
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] red;
  } pixel_t;

  typedef struct packed {
    logic             grey;
    logic [SpanW-1:0] span;
    logic [SpanW-1:0] hue_rem;
    logic [HueW-1:0]  hue_q;
    logic [ChanW-1:0] cmax;
    logic [ChanW-1:0] sat_rem;
    logic [ChanW-1:0] sat_low;
    logic [ChanW-1:0] sat_q;
    logic [ChanW-1:0] alpha;
  } stage_t;

endpackage

// ===== src/rgb_to_hsv_converter_core.sv =====
// An accepted item passes through one front register and four divider stage registers
// before it appears on the master side.
// Throughput: one item per cycle while m_axis_tready is not held low, set by the pipelined restoring dividers that
// resolve four hue bits and two saturation bits in each stage.
// Reset: rst_ni clears all stage valid bits asynchronously; payload is not reset.
module rgb_to_hsv_converter_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // red_in [7:0], green_in [15:8], blue_in [23:16], alpha_in [31:24]
  input  logic [rthc_pkg::InDataW-1:0]    s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // hue_out [15:0], saturation_out [23:16], value_out [31:24], alpha_out [39:32]
  output logic [rthc_pkg::OutDataW-1:0]   m_axis_tdata
);

  rthc_pkg::pixel_t pix;
  logic             valid_s [rthc_pkg::DivStages+1];
  logic             ready_s [rthc_pkg::DivStages+1];
  rthc_pkg::stage_t data_s  [rthc_pkg::DivStages+1];
  rthc_pkg::stage_t last;

  assign pix = s_axis_tdata;

  rthc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .pix_i   (pix),
    .ready_o (s_axis_tready),
    .valid_o (valid_s[0]),
    .data_o  (data_s[0]),
    .ready_i (ready_s[0])
  );

  for (genvar k = 0; k < rthc_pkg::DivStages; k++) begin : g_div
    rthc_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_s[k]),
      .data_i  (data_s[k]),
      .ready_o (ready_s[k]),
      .valid_o (valid_s[k+1]),
      .data_o  (data_s[k+1]),
      .ready_i (ready_s[k+1])
    );
  end

  assign ready_s[rthc_pkg::DivStages] = m_axis_tready;
  assign last                         = data_s[rthc_pkg::DivStages];
  assign m_axis_tvalid                = valid_s[rthc_pkg::DivStages];

  assign m_axis_tdata = {last.alpha,
                         last.cmax,
                         last.grey ? {rthc_pkg::ChanW{1'b0}} : last.sat_q,
                         last.grey ? {rthc_pkg::HueW{1'b0}} : last.hue_q};

`ifndef ASSERT_OFF
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled while output register is empty");

  a_zero_sat_zero_hue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[23:16] == 8'h00) |-> (m_axis_tdata[15:0] == 16'h0000))
    else $error("zero saturation with nonzero hue");

  a_black_is_grey: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[31:24] == 8'h00) |-> (m_axis_tdata[23:16] == 8'h00))
    else $error("black pixel with nonzero saturation");
`endif

endmodule

// ===== src/rthc_front.sv =====
module rthc_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  rthc_pkg::pixel_t pix_i,
  output logic            ready_o,
  output logic            valid_o,
  output rthc_pkg::stage_t data_o,
  input  logic            ready_i
);

  logic                          valid_q;
  rthc_pkg::stage_t              data_d, data_q;
  logic [rthc_pkg::ChanW-1:0]    cmax, cmin, delta;
  logic signed [rthc_pkg::NumW-1:0] num;
  logic [rthc_pkg::SpanW-1:0]    span;
  logic [2*rthc_pkg::ChanW-1:0]  sat_div;

  always_comb begin
    logic [rthc_pkg::ChanW-1:0] mrg, nrg;
    mrg   = (pix_i.red >= pix_i.green) ? pix_i.red : pix_i.green;
    cmax  = (mrg >= pix_i.blue) ? mrg : pix_i.blue;
    nrg   = (pix_i.red <= pix_i.green) ? pix_i.red : pix_i.green;
    cmin  = (nrg <= pix_i.blue) ? nrg : pix_i.blue;
    delta = cmax - cmin;
    span  = {1'b0, delta, 2'b00} + {2'b00, delta, 1'b0};
    if (cmax == pix_i.red) begin
      num = $signed({4'b0, pix_i.green}) - $signed({4'b0, pix_i.blue});
    end else if (cmax == pix_i.green) begin
      num = $signed({3'b0, delta, 1'b0}) + $signed({4'b0, pix_i.blue})
          - $signed({4'b0, pix_i.red});
    end else begin
      num = $signed({2'b0, delta, 2'b00}) + $signed({4'b0, pix_i.red})
          - $signed({4'b0, pix_i.green});
    end
    if (num < 0) begin
      num = num + $signed({1'b0, span});
    end
    sat_div = {delta, 8'h00} - {8'h00, delta};

    data_d.grey    = (delta == '0);
    data_d.span    = span;
    data_d.hue_rem = num[rthc_pkg::SpanW-1:0];
    data_d.hue_q   = '0;
    data_d.cmax    = cmax;
    data_d.sat_rem = sat_div[2*rthc_pkg::ChanW-1:rthc_pkg::ChanW];
    data_d.sat_low = sat_div[rthc_pkg::ChanW-1:0];
    data_d.sat_q   = '0;
    data_d.alpha   = pix_i.alpha;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== src/rthc_div_stage.sv =====
module rthc_div_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  rthc_pkg::stage_t data_i,
  output logic             ready_o,
  output logic             valid_o,
  output rthc_pkg::stage_t data_o,
  input  logic             ready_i
);

  logic             valid_q;
  rthc_pkg::stage_t data_d, data_q;

  // Restoring division: four hue quotient bits and two saturation quotient bits per stage.
  always_comb begin
    logic [rthc_pkg::SpanW:0] th;
    logic [rthc_pkg::ChanW:0] ts;
    data_d = data_i;
    for (int i = 0; i < rthc_pkg::HueBitsPerStage; i++) begin
      th = {data_d.hue_rem, 1'b0};
      if (th >= {1'b0, data_d.span}) begin
        th             = th - {1'b0, data_d.span};
        data_d.hue_q   = {data_d.hue_q[rthc_pkg::HueW-2:0], 1'b1};
      end else begin
        data_d.hue_q   = {data_d.hue_q[rthc_pkg::HueW-2:0], 1'b0};
      end
      data_d.hue_rem = th[rthc_pkg::SpanW-1:0];
    end
    for (int j = 0; j < rthc_pkg::SatBitsPerStage; j++) begin
      ts             = {data_d.sat_rem, data_d.sat_low[rthc_pkg::ChanW-1]};
      data_d.sat_low = {data_d.sat_low[rthc_pkg::ChanW-2:0], 1'b0};
      if (ts >= {1'b0, data_d.cmax}) begin
        ts           = ts - {1'b0, data_d.cmax};
        data_d.sat_q = {data_d.sat_q[rthc_pkg::ChanW-2:0], 1'b1};
      end else begin
        data_d.sat_q = {data_d.sat_q[rthc_pkg::ChanW-2:0], 1'b0};
      end
      data_d.sat_rem = ts[rthc_pkg::ChanW-1:0];
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== tb/tb_top.sv =====
module tb_top;

  localparam int CycleLimit = 200000;
  localparam int ChanW      = rthc_pkg::ChanW;
  localparam int HueW       = rthc_pkg::HueW;
  localparam int InDataW    = rthc_pkg::InDataW;
  localparam int OutDataW   = rthc_pkg::OutDataW;

  typedef struct packed {
    logic [ChanW-1:0] alpha;
    logic [ChanW-1:0] value;
    logic [ChanW-1:0] sat;
    logic [HueW-1:0]  hue;
  } hsv_t;

  class hsv_scoreboard;
    hsv_t expected_hsv_q[$];
    int   errors;

    function new();
      errors = 0;
    endfunction

    function hsv_t predict_hsv(rthc_pkg::pixel_t px);
      hsv_t res;
      int   r;
      int   g;
      int   b;
      int   hi;
      int   lo;
      int   delta;
      int   span;
      int   num;
      r = int'(px.red);
      g = int'(px.green);
      b = int'(px.blue);
      hi = (r > g) ? r : g;
      hi = (hi > b) ? hi : b;
      lo = (r < g) ? r : g;
      lo = (lo < b) ? lo : b;
      delta = hi - lo;
      res.hue   = '0;
      res.sat   = '0;
      res.value = hi[ChanW-1:0];
      res.alpha = px.alpha;
      if (delta != 0) begin
        span = 6 * delta;
        if (hi == r) begin
          num = g - b;
        end else if (hi == g) begin
          num = 2 * delta + b - r;
        end else begin
          num = 4 * delta + r - g;
        end
        if (num < 0) begin
          num = num + span;
        end
        res.hue = HueW'((num * 65536) / span);
        res.sat = ChanW'((255 * delta) / hi);
      end
      return res;
    endfunction

    function void note_pixel(rthc_pkg::pixel_t px);
      expected_hsv_q.push_back(predict_hsv(px));
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        errors++;
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_hsv(hsv_t got);
      hsv_t want;
      if (expected_hsv_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected item, expected none, got %h", $time, got);
      end else begin
        want = expected_hsv_q.pop_front();
        compare_field("hue", int'(want.hue), int'(got.hue));
        compare_field("saturation", int'(want.sat), int'(got.sat));
        compare_field("value", int'(want.value), int'(got.value));
        compare_field("alpha", int'(want.alpha), int'(got.alpha));
      end
    endfunction

    function int pending();
      return expected_hsv_q.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;

  hsv_scoreboard sb;
  int            src_idle_pct;
  int            sink_stall_pct;
  int            hold_cycles;
  int            cycle_count;

  logic [InDataW-1:0] directed_px [22] = '{
    32'h00000000, 32'hFFFFFFFF, 32'h000000FF, 32'h0000FF00, 32'h00FF0000,
    32'hFF00FFFF, 32'h7FFFFF00, 32'h01FF00FF, 32'h40808080, 32'h00C700C8,
    32'hAA010000, 32'h55000001, 32'h00000100, 32'hFFFEFEFF, 32'h00050AC8,
    32'h0005C80A, 32'h00C8050A, 32'h00C80A05, 32'h000AC805, 32'h00010101,
    32'h80000101, 32'hFF01FFFE
  };
  int idle_mix [4][2] = '{'{0, 0}, '{67, 0}, '{0, 67}, '{16, 16}};

  rgb_to_hsv_converter_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    m_axis_tready  = 1'b0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_cycles    = 0;
    cycle_count    = 0;
    sb             = new();
  end

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("rgb_to_hsv_converter_core: mismatch");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      m_axis_tready = 1'b0;
      hold_cycles   = hold_cycles - 1;
    end else begin
      m_axis_tready = ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_hsv(hsv_t'(m_axis_tdata));
    end
  end

  task automatic send_pixel(input rthc_pkg::pixel_t px);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = px;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_pixel(px);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic rthc_pkg::pixel_t random_pixel();
    rthc_pkg::pixel_t px;
    int               kind;
    int               base;
    kind = $urandom_range(9);
    px = rthc_pkg::pixel_t'($urandom);
    base = $urandom_range(255);
    case (kind)
      0: begin
        px.red   = ChanW'(base);
        px.green = ChanW'(base);
        px.blue  = ChanW'(base);
      end
      1: begin
        px.red   = ChanW'(base);
        px.green = ChanW'(base);
        px.blue  = ChanW'($urandom_range(base));
      end
      2: begin
        px.green = ChanW'(base);
        px.blue  = ChanW'(base);
        px.red   = ChanW'($urandom_range(base));
      end
      3: begin
        px.red   = ChanW'(base);
        px.blue  = ChanW'(base);
        px.green = ChanW'($urandom_range(base));
      end
      4: begin
        px.red   = ChanW'(base);
        px.green = (base > 0) ? ChanW'(base - int'($urandom_range(1))) : '0;
        px.blue  = (base > 0) ? ChanW'(base - int'($urandom_range(1))) : '0;
      end
      default: begin
      end
    endcase
    return px;
  endfunction

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_px[i]) begin
      send_pixel(rthc_pkg::pixel_t'(directed_px[i]));
    end
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct   = idle_mix[ph][0];
      sink_stall_pct = idle_mix[ph][1];
      if (ph == 0) begin
        @(posedge clk_i);
        hold_cycles = 150;
      end
      for (int n = 0; n < 320; n++) begin
        send_pixel(random_pixel());
      end
      wait_drained();
    end

    repeat (12) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("rgb_to_hsv_converter_core: match");
    end else begin
      $display("rgb_to_hsv_converter_core: mismatch");
    end
    $finish;
  end

endmodule
